// ----- hw/rtl/rfr_pkg.sv -----
// Package for the rightmost free-run finder: sizes, request codes and the
// run-tracking types shared by the bitmap, the scan unit and the top level.
// No dependencies.
package rfr_pkg;

	localparam int POSITIONS = 1024;
	localparam int WORD_W    = 8;
	localparam int WORDS     = POSITIONS / WORD_W;
	localparam int IDX_W     = $clog2(POSITIONS);
	localparam int ADDR_W    = $clog2(WORDS);
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int FIELD_W   = 11;
	localparam int TYPE_W    = 2;

	localparam logic [TYPE_W-1:0] REQ_CLEAR  = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_OCCUPY = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_QUERY  = 2'd2;

	// Free run being tracked while scanning from the right.
	typedef struct packed {
		logic [FIELD_W-1:0] run_len;
		logic [FIELD_W-1:0] run_end;
	} run_state_t;

	// What the scan unit reports for one bitmap word.
	typedef struct packed {
		run_state_t         next;
		logic               hit;
		logic [FIELD_W-1:0] hit_end;
	} scan_result_t;

endpackage

// ----- hw/rtl/rfr_req_if.sv -----
// Request channel of the rightmost free-run finder: valid/ready plus fields.
// Depends on rfr_pkg.
interface rfr_req_if;
	import rfr_pkg::*;

	logic               valid;
	logic               ready;
	logic [TYPE_W-1:0]  req_type;
	logic [FIELD_W-1:0] first_pos;
	logic [FIELD_W-1:0] last_pos;
	logic [FIELD_W-1:0] want_length;

	modport source (output valid, output req_type, output first_pos, output last_pos,
		output want_length, input ready);
	modport sink (input valid, input req_type, input first_pos, input last_pos,
		input want_length, output ready);
endinterface

// ----- hw/rtl/rfr_res_if.sv -----
// Result channel of the rightmost free-run finder: valid/ready plus fields.
// Depends on rfr_pkg.
interface rfr_res_if;
	import rfr_pkg::*;

	logic               valid;
	logic               ready;
	logic               found;
	logic [FIELD_W-1:0] window_start;
	logic [FIELD_W-1:0] window_end;

	modport source (output valid, output found, output window_start, output window_end,
		input ready);
	modport sink (input valid, input found, input window_start, input window_end,
		output ready);
endinterface

// ----- hw/rtl/rfr_bitmap.sv -----
// Occupancy bitmap memory, one word per row, with a valid bit per row so a
// clear only has to drop the valid bits. Registered read data. Depends on rfr_pkg.
module rfr_bitmap (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic                        rd_en,
	input  logic [rfr_pkg::ADDR_W-1:0]  rd_addr,
	output logic [rfr_pkg::WORD_W-1:0]  rd_data,
	input  logic                        wr_en,
	input  logic [rfr_pkg::ADDR_W-1:0]  wr_addr,
	input  logic [rfr_pkg::WORD_W-1:0]  wr_data
);
	import rfr_pkg::*;

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORDS-1:0]  row_valid_q;
	logic [WORD_W-1:0] rd_word_q;
	logic              rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (clear) begin
				row_valid_q <= '0;
			end else if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= row_valid_q[rd_addr];
			end
		end
	end

	// A row never written since the last clear reads as all free.
	assign rd_data = rd_valid_q ? rd_word_q : '0;
endmodule

// ----- hw/rtl/rfr_word_scan.sv -----
// Shared scan unit: walks one bitmap word from its top bit down, carrying the
// current free run, and reports the first run long enough. Depends on rfr_pkg.
module rfr_word_scan (
	input  logic [rfr_pkg::WORD_W-1:0]  word,
	input  logic [rfr_pkg::ADDR_W-1:0]  word_addr,
	input  logic [rfr_pkg::IDX_W-1:0]   limit_idx,
	input  logic [rfr_pkg::FIELD_W-1:0] want,
	input  logic                        is_last,
	input  rfr_pkg::run_state_t         cur,
	output rfr_pkg::scan_result_t       res
);
	import rfr_pkg::*;

	always_comb begin
		logic [FIELD_W-1:0] len;
		logic [FIELD_W-1:0] rend;
		logic [FIELD_W-1:0] pos;
		logic [IDX_W-1:0]   idx;
		logic               hit;
		logic [FIELD_W-1:0] hit_end;
		logic               is_free;
		len     = cur.run_len;
		rend    = cur.run_end;
		hit     = 1'b0;
		hit_end = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			idx     = {word_addr, BIT_W'(b)};
			pos     = FIELD_W'(idx) + FIELD_W'(1);
			is_free = (idx <= limit_idx) && !word[b];
			if (!hit) begin
				if (is_free) begin
					if (len == '0) begin
						rend = pos;
					end
					len = len + FIELD_W'(1);
				end else begin
					if (len >= want) begin
						hit     = 1'b1;
						hit_end = rend;
					end
					len = '0;
				end
			end
		end
		// Position zero acts as an occupied cell that closes the last run.
		if (!hit && is_last && len >= want) begin
			hit     = 1'b1;
			hit_end = rend;
		end
		res.next.run_len = len;
		res.next.run_end = rend;
		res.hit          = hit;
		res.hit_end      = hit_end;
	end
endmodule

// ----- hw/rtl/rightmost_free_run_finder.sv -----
// Rightmost free-run finder top level: request sequencer, count register and
// result register. Depends on rfr_pkg, rfr_req_if, rfr_res_if, rfr_bitmap, rfr_word_scan.
//
// The block keeps an occupancy bitmap over positions 1 to position_count
// (clamped to 1024), stored as 128 words of 8 bits in a single-port-read memory.
// A clear item drops a valid bit per row, so there is no clearing pass after
// reset or after a clear. An occupy item does one read-modify-write per word
// it spans. A query item with a nonzero length and count walks the map from
// the word that holds the configured count down to word 0, one word per cycle,
// through the single read port and one shared word-scan unit, and stops at
// the first run long enough. One item is worked on at a time; the result waits
// in an output register so the next item can be accepted while the result is
// still not taken. Items with an unknown request code are taken and ignored.
// The user must write position_count through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce it.
module rightmost_free_run_finder (
	input  logic                        clk,
	input  logic                        arst_n,
	rfr_req_if.sink                     req,
	rfr_res_if.source                   res,
	input  logic                        cfg_we,
	input  logic [rfr_pkg::FIELD_W-1:0] cfg_wdata
);
	import rfr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_OCC  = 4'b0010,
		ST_QRY  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [FIELD_W-1:0]  count_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ADDR_W-1:0]   end_addr_q;
	logic                issue_q;
	logic [IDX_W-1:0]    lo_q;
	logic [IDX_W-1:0]    hi_q;
	logic [FIELD_W-1:0]  want_q;
	run_state_t          run_q;
	logic                pend_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic                hit_q;
	logic [FIELD_W-1:0]  hit_start_q;
	logic [FIELD_W-1:0]  hit_end_q;
	logic                res_valid_q;
	logic                res_found_q;
	logic [FIELD_W-1:0]  res_start_q;
	logic [FIELD_W-1:0]  res_end_q;

	// Effective count and the derived occupy interval of the incoming item.
	logic [FIELD_W-1:0]  count_eff;
	logic [IDX_W-1:0]    limit_idx;
	logic [FIELD_W-1:0]  first_adj;
	logic [FIELD_W-1:0]  last_clamped;
	logic [FIELD_W-1:0]  lo_full;
	logic [FIELD_W-1:0]  hi_full;
	logic                occ_empty;
	logic                accept;

	assign count_eff    = (count_q > FIELD_W'(POSITIONS)) ? FIELD_W'(POSITIONS) : count_q;
	assign limit_idx    = IDX_W'(count_eff - FIELD_W'(1));
	assign first_adj    = (req.first_pos == '0) ? FIELD_W'(1) : req.first_pos;
	assign last_clamped = (req.last_pos > count_eff) ? count_eff : req.last_pos;
	assign occ_empty    = (first_adj > last_clamped);
	assign lo_full      = first_adj - FIELD_W'(1);
	assign hi_full      = last_clamped - FIELD_W'(1);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	// Memory access: one read per cycle while a walk is issuing.
	logic              rd_en;
	logic [WORD_W-1:0] rd_data;
	logic              wr_en;
	logic [WORD_W-1:0] wr_data;
	logic              clear;

	assign rd_en = issue_q && ((state_q == ST_OCC) || (state_q == ST_QRY));
	assign clear = accept && (req.req_type == REQ_CLEAR);
	assign wr_en = pend_s1 && (state_q == ST_OCC);

	// Occupy mask for the word coming back from the memory.
	logic [BIT_W-1:0]  lo_bit;
	logic [BIT_W-1:0]  hi_bit;
	logic [WORD_W-1:0] occ_mask;

	assign lo_bit   = (addr_s1 == lo_q[IDX_W-1:BIT_W]) ? lo_q[BIT_W-1:0] : '0;
	assign hi_bit   = (addr_s1 == hi_q[IDX_W-1:BIT_W]) ? hi_q[BIT_W-1:0] : BIT_W'(WORD_W - 1);
	assign occ_mask = ({WORD_W{1'b1}} << lo_bit)
		& ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_bit));
	assign wr_data  = rd_data | occ_mask;

	rfr_bitmap u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (clear),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (wr_data)
	);

	scan_result_t scan;

	rfr_word_scan u_scan (
		.word      (rd_data),
		.word_addr (addr_s1),
		.limit_idx (limit_idx),
		.want      (want_q),
		.is_last   (addr_s1 == '0),
		.cur       (run_q),
		.res       (scan)
	);

	logic out_free;
	assign out_free = !res_valid_q || res.ready;

	// Read pipeline: marks which word the registered read data belongs to.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1 <= addr_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= 1'b0;
			count_q     <= FIELD_W'(POSITIONS);
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			// The output register fills as a query finishes and empties once taken.
			if (state_q == ST_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_OCCUPY: begin
								if (!occ_empty) begin
									issue_q <= 1'b1;
									state_q <= ST_OCC;
								end
							end
							REQ_QUERY: begin
								if (req.want_length == '0 || count_eff == '0) begin
									state_q <= ST_OUT;
								end else begin
									issue_q <= 1'b1;
									state_q <= ST_QRY;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_OCC: begin
					if (rd_en && addr_q == end_addr_q) begin
						issue_q <= 1'b0;
					end
					if (!issue_q && !pend_s1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QRY: begin
					if ((rd_en && addr_q == '0)
						|| (pend_s1 && (scan.hit || addr_s1 == '0))) begin
						issue_q <= 1'b0;
					end
					if (pend_s1 && (scan.hit || addr_s1 == '0)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk address, interval bounds, run tracking and the finished result.
	always_ff @(posedge clk) begin
		if (accept) begin
			want_q      <= req.want_length;
			lo_q        <= IDX_W'(lo_full);
			hi_q        <= IDX_W'(hi_full);
			end_addr_q  <= hi_full[IDX_W-1:BIT_W];
			run_q       <= '0;
			hit_q       <= 1'b0;
			hit_start_q <= '0;
			hit_end_q   <= '0;
			if (req.req_type == REQ_QUERY) begin
				addr_q <= limit_idx[IDX_W-1:BIT_W];
			end else begin
				addr_q <= lo_full[IDX_W-1:BIT_W];
			end
		end else begin
			if (rd_en) begin
				addr_q <= (state_q == ST_QRY) ? addr_q - ADDR_W'(1) : addr_q + ADDR_W'(1);
			end
			if (state_q == ST_QRY && pend_s1) begin
				run_q <= scan.next;
				if (scan.hit) begin
					hit_q       <= 1'b1;
					hit_end_q   <= scan.hit_end;
					hit_start_q <= scan.hit_end - want_q + FIELD_W'(1);
				end
			end
		end
		if (state_q == ST_OUT && out_free) begin
			res_found_q <= hit_q;
			res_start_q <= hit_start_q;
			res_end_q   <= hit_end_q;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.found        = res_found_q;
	assign res.window_start = res_start_q;
	assign res.window_end   = res_end_q;
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for rightmost_free_run_finder: directed and random
// clear, occupy and query traffic against a bitmap predictor, under random idling.
// Depends on rfr_pkg, rfr_req_if, rfr_res_if and the block's RTL.
module tb_top;
	import rfr_pkg::*;

	// Request code 3 has no meaning; the block must take such an item and drop it.
	localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

	localparam int CLK_PERIOD      = 12;
	localparam int RESET_CYCLES    = 10;
	// A query or an occupy may walk all 128 words; this wait after the last result
	// is long enough for the block to be idle again.
	localparam int SETTLE_CYCLES   = 140;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int REPORT_LIMIT    = 10;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 94;
	localparam int RESET_COUNT     = 1024;

	typedef logic [FIELD_W-1:0] field_t;

	typedef struct packed {
		logic [TYPE_W-1:0] req_type;
		field_t            first_pos;
		field_t            last_pos;
		field_t            want_length;
	} request_t;

	typedef struct packed {
		logic   found;
		field_t window_start;
		field_t window_end;
	} window_t;

	logic   clk;
	logic   arst_n;
	logic   cfg_we;
	field_t cfg_wdata;

	rfr_req_if req_ch();
	rfr_res_if res_ch();

	rightmost_free_run_finder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch.sink),
		.res      (res_ch.source),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the block's state. Position p lives in occupied[p]; bits above
	// the live count are kept, exactly as the block keeps them across count changes.
	bit      occupied [1:POSITIONS];
	field_t  position_count = field_t'(RESET_COUNT);

	// Windows that queries already taken by the block must still produce, oldest first.
	window_t pending_windows [$];

	int mismatch_count  = 0;
	int burst_left      = 0;
	bit sender_gaps_on  = 1'b1;
	// Set by a test to make the result side refuse every item for that many cycles.
	int hold_off_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// The count register is 11 bits wide, but only 1024 positions exist.
	function automatic int unsigned live_positions();
		return (position_count > POSITIONS) ? POSITIONS : position_count;
	endfunction

	// Walks from the top live position downward. A run is only judged once an
	// occupied cell, or the edge below position 1, closes it; the first closed run
	// that is long enough wins, and the window is flush with its right end.
	function automatic window_t find_rightmost_window(field_t want);
		window_t     win;
		int unsigned limit;
		int unsigned run_len;
		int unsigned run_end;
		int          p;
		bit          is_free;
		win   = '0;
		limit = live_positions();
		if (want == 0 || limit == 0)
			return win;
		run_len = 0;
		run_end = 0;
		for (p = limit; p >= 0; p--) begin
			is_free = (p >= 1) && !occupied[p];
			if (is_free) begin
				if (run_len == 0)
					run_end = p;
				run_len++;
			end else begin
				if (run_len >= want) begin
					win.found        = 1'b1;
					win.window_end   = field_t'(run_end);
					win.window_start = field_t'(run_end - want + 1);
					return win;
				end
				run_len = 0;
			end
		end
		return win;
	endfunction

	// Updates the shadow map for one item the block has taken, and queues the
	// answer a query must give.
	function automatic void apply_request(request_t rq);
		int unsigned first;
		int unsigned last;
		int unsigned p;
		case (rq.req_type)
			REQ_CLEAR: begin
				foreach (occupied[i])
					occupied[i] = 1'b0;
			end
			REQ_OCCUPY: begin
				// A zero first position means position 1; the end is cut at the count.
				first = (rq.first_pos == 0) ? 1 : rq.first_pos;
				last  = (rq.last_pos > live_positions()) ? live_positions() : rq.last_pos;
				for (p = first; p <= last; p++)
					occupied[p] = 1'b1;
			end
			REQ_QUERY:
				pending_windows.insert(pending_windows.size(),
					find_rightmost_window(rq.want_length));
			default: ;
		endcase
	endfunction

	function automatic void note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $time, msg);
	endfunction

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// Offers one item and returns at the rising edge where it was taken. It is
	// entered and left at a rising edge, so back-to-back calls that draw no gap
	// keep valid high without a drop in between. The handshake is judged at the
	// falling edge, where every signal has settled.
	task automatic send_request(input logic [TYPE_W-1:0] kind, input int unsigned first_pos,
		input int unsigned last_pos, input int unsigned want_length);
		request_t    rq;
		int unsigned gap;
		rq.req_type    = kind;
		rq.first_pos   = field_t'(first_pos);
		rq.last_pos    = field_t'(last_pos);
		rq.want_length = field_t'(want_length);
		if (sender_gaps_on && burst_left == 0) begin
			// Mostly short gaps, now and then a long one, sometimes none at all.
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= rq.req_type;
		req_ch.first_pos   <= rq.first_pos;
		req_ch.last_pos    <= rq.last_pos;
		req_ch.want_length <= rq.want_length;
		do
			@(negedge clk);
		while (!req_ch.ready);
		@(posedge clk);
		if (burst_left > 0)
			burst_left--;
		apply_request(rq);
	endtask

	// Stops offering items and waits until every queued answer has come back,
	// then lets the block finish any occupy that gives no answer.
	task automatic drain_results();
		int waited;
		req_ch.valid <= 1'b0;
		waited = 0;
		while (pending_windows.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_windows.size() != 0) begin
			note_mismatch($sformatf("%0d queued answers never arrived", pending_windows.size()));
			pending_windows.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The count is only changed while the block is idle.
	task automatic write_position_count(input int unsigned value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= field_t'(value);
		@(posedge clk);
		cfg_we         <= 1'b0;
		position_count  = field_t'(value);
	endtask

	// ------------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------------

	// Ready follows the bits of a 16-bit pattern in turn, redrawn each time it runs out:
	// all ones, random, mostly ready or mostly stalled. A hold-off request from a
	// test overrides the pattern and is counted down here.
	initial begin : result_sink
		logic [15:0] stall_pattern;
		int          slot;
		stall_pattern  = '1;
		slot           = 0;
		res_ch.ready  <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				res_ch.ready <= 1'b0;
			end else begin
				if (slot == 0) begin
					case ($urandom_range(0, 3))
						0: stall_pattern = '1;
						1: stall_pattern = 16'($urandom);
						2: stall_pattern = 16'($urandom) | 16'($urandom);
						default: stall_pattern = 16'($urandom) & 16'($urandom);
					endcase
				end
				res_ch.ready <= stall_pattern[slot];
				slot = (slot + 1) % 16;
			end
		end
	end

	// Every result taken is compared field by field with the oldest queued answer.
	always @(negedge clk) begin : result_check
		window_t want_win;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_windows.size() == 0) begin
				note_mismatch($sformatf("result with no query waiting: found=%0b start=%0d end=%0d",
					res_ch.found, res_ch.window_start, res_ch.window_end));
			end else begin
				want_win = pending_windows.pop_front();
				if (res_ch.found !== want_win.found)
					note_mismatch($sformatf("found: expected %0b, got %0b",
						want_win.found, res_ch.found));
				if (res_ch.window_start !== want_win.window_start)
					note_mismatch($sformatf("window_start: expected %0d, got %0d",
						want_win.window_start, res_ch.window_start));
				if (res_ch.window_end !== want_win.window_end)
					note_mismatch($sformatf("window_end: expected %0d, got %0d",
						want_win.window_end, res_ch.window_end));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Right after reset the whole map of 1024 positions is free.
	task automatic test_empty_map_queries();
		send_request(REQ_QUERY, 0, 0, 1);
		send_request(REQ_QUERY, 2047, 2047, RESET_COUNT);
		send_request(REQ_QUERY, 0, 0, RESET_COUNT + 1);
		send_request(REQ_QUERY, 0, 0, 0);
		send_request(REQ_QUERY, 0, 0, 2047);
	endtask

	// Interval edges: a zero first position, an end far past the count, an empty
	// interval, one wholly beyond the count, and an unknown code that must change
	// nothing. The queries then probe the run left between positions 4 and 1019.
	task automatic test_occupy_edges();
		send_request(REQ_OCCUPY, 0, 3, 0);
		send_request(REQ_OCCUPY, 1020, 2047, 0);
		send_request(REQ_OCCUPY, 600, 500, 0);
		send_request(REQ_OCCUPY, 1500, 1600, 0);
		send_request(REQ_UNUSED, 1, 2047, 2047);
		send_request(REQ_QUERY, 0, 0, 1);
		send_request(REQ_QUERY, 0, 0, 1016);
		send_request(REQ_QUERY, 0, 0, 1017);
		send_request(REQ_CLEAR, 2047, 2047, 2047);
		send_request(REQ_QUERY, 0, 0, RESET_COUNT);
	endtask

	// A count of zero leaves nothing to occupy or find; a count of one is the
	// smallest map; 2047 is cut to 1024. Shrinking the count hides occupied bits
	// above it, and growing it again brings them back.
	task automatic test_count_register();
		write_position_count(0);
		send_request(REQ_OCCUPY, 1, 5, 0);
		send_request(REQ_QUERY, 0, 0, 1);
		write_position_count(1);
		send_request(REQ_QUERY, 0, 0, 1);
		send_request(REQ_OCCUPY, 1, 1, 0);
		send_request(REQ_QUERY, 0, 0, 1);
		write_position_count(2047);
		send_request(REQ_OCCUPY, 900, 1000, 0);
		write_position_count(950);
		send_request(REQ_QUERY, 0, 0, 60);
		send_request(REQ_QUERY, 0, 0, 1);
		write_position_count(RESET_COUNT);
		send_request(REQ_QUERY, 0, 0, 24);
	endtask

	// The result side refuses everything for a long stretch while items keep
	// coming with no gaps, so the output register and the worker fill and the
	// request side has to stall. Afterwards the sender waits for every answer.
	task automatic test_backpressure();
		int n;
		sender_gaps_on  = 1'b0;
		hold_off_cycles = HOLD_OFF_CYCLES;
		for (n = 0; n < 30; n++) begin
			if (n % 3 == 0)
				send_request(REQ_OCCUPY, $urandom_range(1, 1000), $urandom_range(1, 1024), 0);
			else
				send_request(REQ_QUERY, 0, 0, $urandom_range(1, 40));
		end
		sender_gaps_on = 1'b1;
		drain_results();
	endtask

	function automatic int unsigned pick_want_length();
		int unsigned limit;
		limit = live_positions();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return $urandom_range(0, 2047);
			2, 3: return limit + $urandom_range(0, 2);
			4, 5, 6, 7, 8, 9: return $urandom_range(1, (limit > 0) ? limit : 1);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	// Phases at several counts, small ones mostly. Each phase is a stream of
	// occupies of short intervals inside the count, queries of varied lengths and
	// the odd clear, so the map builds up real structure between clears. Noise
	// items carry random values in every field. Unless a phase opens with a clear,
	// the map carries over into it, so count changes meet bits above the new count.
	task automatic test_random_traffic();
		int unsigned counts [16] = '{16, 64, 1, 2, 37, 200, 1024, 8, 130, 2047, 100, 5,
			1024, 0, 48, 300};
		int          phase;
		int          sent;
		int unsigned limit;
		int unsigned span;
		int unsigned first;
		int unsigned pick;
		for (phase = 0; phase < 16; phase++) begin
			write_position_count(counts[phase]);
			if ($urandom_range(0, 1))
				send_request(REQ_CLEAR, 0, 0, 0);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				limit = live_positions();
				span  = (limit / 6 > 1) ? limit / 6 : 1;
				pick  = $urandom_range(0, 99);
				if (pick < 4) begin
					send_request(REQ_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 2047),
						$urandom_range(0, 2047));
					sent++;
				end else if (pick < 40) begin
					first = $urandom_range(1, (limit > 0) ? limit : 16);
					send_request(REQ_OCCUPY, first, first + $urandom_range(0, span - 1),
						$urandom_range(0, 2047));
					sent++;
				end else if (pick < 44) begin
					send_request(REQ_OCCUPY, $urandom_range(0, 2047), $urandom_range(0, 2047),
						$urandom_range(0, 2047));
					sent++;
				end else if (pick < 47) begin
					// Ignored by the block, so it does not count as traffic.
					send_request(REQ_UNUSED, $urandom_range(0, 2047), $urandom_range(0, 2047),
						$urandom_range(0, 2047));
				end else begin
					send_request(REQ_QUERY, $urandom_range(0, 2047), $urandom_range(0, 2047),
						pick_want_length());
					sent++;
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= REQ_CLEAR;
		req_ch.first_pos   <= '0;
		req_ch.last_pos    <= '0;
		req_ch.want_length <= '0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		arst_n             <= 1'b0;
		foreach (occupied[i])
			occupied[i] = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_empty_map_queries();
		test_occupy_edges();
		test_count_register();
		test_backpressure();
		test_random_traffic();
		drain_results();

		if (mismatch_count == 0) begin
			$display("rightmost_free_run_finder regression: pass");
		end else begin
			$display("rightmost_free_run_finder regression: fail");
		end
		$finish;
	end

	// Far beyond the slowest correct run: every item a full-map query waiting out
	// the longest stalls and gaps, plus the drains between phases.
	initial begin
		#(CLK_PERIOD * 2000000);
		$display("rightmost_free_run_finder regression: fail");
		$finish;
	end

endmodule
